FILE: hdl/assert_macros.svh
// assertion macros used by the deque engine sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define OLDQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("oldq: property violated");

// condition must never be seen outside reset
`define OLDQ_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("oldq: forbidden condition seen");

`else

`define OLDQ_ASSERT(lbl, clk, rst_n, prop)
`define OLDQ_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

FILE: hdl/oldq_pkg.sv
// types and codes of the ordered list deque engine
package oldq_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_REAR  = 3'd1,
        CMD_DEL_FRONT = 3'd2,
        CMD_DEL_REAR  = 3'd3,
        CMD_DEL_KEY   = 3'd4,
        CMD_READ_OUT  = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EMPTY     = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FETCH,
        ST_SCAN,
        ST_SHIFT,
        ST_READOUT,
        ST_REPLY
    } state_t;

    typedef struct packed {
        cmd_t                     command;
        logic signed [DATA_W-1:0] operand_value;
    } cmd_item_t;

    typedef struct packed {
        status_t                  status;
        logic signed [DATA_W-1:0] result_value;
        logic                     last;
    } rsp_item_t;

    // one result handed from the sequencer to the output register
    typedef struct packed {
        logic      valid;
        rsp_item_t item;
    } res_push_t;

endpackage

FILE: hdl/ordered_list_deque_engine.sv
// ordered list deque engine top level: sequencer, element store and result register
// Holds up to DEPTH signed 32-bit values in a circular store and serves one command at a
// time. A delete by key and a read-out walk every element held through the single read
// port of the element store, one element per cycle; a read-out pauses while the output
// register is stalled. While a command is in work cmd_stall stays high; the next command
// is taken as soon as its last result sits in the output register, even if that result
// is still stalled.
module ordered_list_deque_engine #(
    parameter int DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  oldq_pkg::cmd_item_t cmd,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output oldq_pkg::rsp_item_t rsp
);

    logic                rsp_valid_reg;
    oldq_pkg::rsp_item_t rsp_reg;
    oldq_pkg::res_push_t push;
    logic                out_free;

    assign out_free = !rsp_valid_reg || !rsp_stall;

    oldq_seq #(
        .DEPTH(DEPTH)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd      (cmd),
        .out_free (out_free),
        .push     (push)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (push.valid)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            rsp_reg <= push.item;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: hdl/oldq_ram.sv
// generic simple dual port ram with registered read
module oldq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/oldq_seq.sv
// command sequencer: walks the circular element store one slot per cycle unless stalled
`include "assert_macros.svh"

module oldq_seq #(
    parameter int DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  oldq_pkg::cmd_item_t cmd,
    input  logic                out_free,
    output oldq_pkg::res_push_t push
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] HEAD_MAX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(DEPTH);

    oldq_pkg::state_t  state_reg, state_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [AW-1:0]     prev_slot_reg, prev_slot_next;
    logic [AW-1:0]     rd_addr_reg;
    oldq_pkg::cmd_t    cmd_reg, cmd_next;
    logic signed [oldq_pkg::DATA_W-1:0] val_reg, val_next;
    oldq_pkg::status_t reply_status_reg, reply_status_next;
    logic signed [oldq_pkg::DATA_W-1:0] reply_value_reg, reply_value_next;

    logic [AW-1:0]     pos;
    logic [AW-1:0]     slot;
    logic [AW-1:0]     head_inc;
    logic [AW-1:0]     head_dec;
    logic [CW-1:0]     idx_inc;
    logic              full;
    logic              empty;
    logic              cmd_xfer;
    logic              in_shift;

    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [oldq_pkg::DATA_W-1:0]  wr_data;
    logic                         rd_en;
    logic [AW-1:0]                rd_addr;
    logic [oldq_pkg::DATA_W-1:0]  rd_data;

    // position to slot: head plus offset, wrapped once
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [AW-1:0] offset);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, offset};
        if (sum >= DEPTH_W)
        begin
            sum = sum - DEPTH_W;
        end
        return sum[AW-1:0];
    endfunction

    oldq_ram #(
        .WIDTH(oldq_pkg::DATA_W),
        .DEPTH(DEPTH)
    ) u_store (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign cmd_stall = (state_reg != oldq_pkg::ST_IDLE);
    assign idx_inc   = CW'(idx_reg) + CW'(1);
    assign full      = (count_reg == COUNT_MAX);
    assign empty     = (count_reg == '0);
    assign head_inc  = (head_reg == HEAD_MAX) ? '0 : head_reg + AW'(1);
    assign head_dec  = (head_reg == '0) ? HEAD_MAX : head_reg - AW'(1);
    assign cmd_xfer  = cmd_valid && !cmd_stall;
    assign in_shift  = (state_reg == oldq_pkg::ST_SHIFT);

    // offset into the list for the one shared slot adder
    always_comb
    begin
        pos = idx_inc[AW-1:0];
        if (state_reg == oldq_pkg::ST_DECODE)
        begin
            if (cmd_reg == oldq_pkg::CMD_INS_REAR)
            begin
                pos = count_reg[AW-1:0];
            end
            else if (cmd_reg == oldq_pkg::CMD_DEL_REAR)
            begin
                pos = AW'(count_reg - CW'(1));
            end
            else
            begin
                pos = '0;
            end
        end
    end

    assign slot = slot_of(head_reg, pos);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= oldq_pkg::ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg          <= idx_next;
        prev_slot_reg    <= prev_slot_next;
        cmd_reg          <= cmd_next;
        val_reg          <= val_next;
        reply_status_reg <= reply_status_next;
        reply_value_reg  <= reply_value_next;
        if (rd_en)
        begin
            rd_addr_reg <= rd_addr;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        head_next         = head_reg;
        count_next        = count_reg;
        idx_next          = idx_reg;
        prev_slot_next    = prev_slot_reg;
        cmd_next          = cmd_reg;
        val_next          = val_reg;
        reply_status_next = reply_status_reg;
        reply_value_next  = reply_value_reg;
        wr_en             = 1'b0;
        wr_addr           = slot;
        wr_data           = val_reg;
        rd_en             = 1'b0;
        rd_addr           = slot;
        push.valid        = 1'b0;
        push.item.status       = reply_status_reg;
        push.item.result_value = reply_value_reg;
        push.item.last         = 1'b1;

        unique case (state_reg)
            oldq_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd.command;
                    val_next   = cmd.operand_value;
                    state_next = oldq_pkg::ST_DECODE;
                end
            end

            oldq_pkg::ST_DECODE:
            begin
                reply_status_next = oldq_pkg::STATUS_OK;
                reply_value_next  = '0;
                state_next        = oldq_pkg::ST_REPLY;
                unique case (cmd_reg) inside
                    oldq_pkg::CMD_INS_FRONT:
                    begin
                        if (full)
                        begin
                            reply_status_next = oldq_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = head_dec;
                            head_next  = head_dec;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    oldq_pkg::CMD_INS_REAR:
                    begin
                        if (full)
                        begin
                            reply_status_next = oldq_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    oldq_pkg::CMD_DEL_FRONT:
                    begin
                        if (empty)
                        begin
                            reply_status_next = oldq_pkg::STATUS_EMPTY;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = head_reg;
                            head_next  = head_inc;
                            count_next = count_reg - CW'(1);
                            state_next = oldq_pkg::ST_FETCH;
                        end
                    end
                    oldq_pkg::CMD_DEL_REAR:
                    begin
                        if (empty)
                        begin
                            reply_status_next = oldq_pkg::STATUS_EMPTY;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            count_next = count_reg - CW'(1);
                            state_next = oldq_pkg::ST_FETCH;
                        end
                    end
                    oldq_pkg::CMD_DEL_KEY, oldq_pkg::CMD_READ_OUT:
                    begin
                        if (empty)
                        begin
                            reply_status_next = oldq_pkg::STATUS_EMPTY;
                        end
                        else
                        begin
                            rd_en    = 1'b1;
                            idx_next = '0;
                            state_next = (cmd_reg == oldq_pkg::CMD_DEL_KEY) ?
                                         oldq_pkg::ST_SCAN : oldq_pkg::ST_READOUT;
                        end
                    end
                    default:
                    begin
                        // unused command codes give no reply and leave the store untouched
                        state_next = oldq_pkg::ST_IDLE;
                    end
                endcase
            end

            oldq_pkg::ST_FETCH:
            begin
                reply_value_next = rd_data;
                state_next       = oldq_pkg::ST_REPLY;
            end

            oldq_pkg::ST_SCAN:
            begin
                if (rd_data == val_reg)
                begin
                    reply_status_next = oldq_pkg::STATUS_OK;
                    reply_value_next  = rd_data;
                    prev_slot_next    = rd_addr_reg;
                    if (idx_inc < count_reg)
                    begin
                        rd_en      = 1'b1;
                        idx_next   = idx_inc[AW-1:0];
                        state_next = oldq_pkg::ST_SHIFT;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                        state_next = oldq_pkg::ST_REPLY;
                    end
                end
                else if (idx_inc < count_reg)
                begin
                    rd_en    = 1'b1;
                    idx_next = idx_inc[AW-1:0];
                end
                else
                begin
                    reply_status_next = oldq_pkg::STATUS_NOT_FOUND;
                    reply_value_next  = '0;
                    state_next        = oldq_pkg::ST_REPLY;
                end
            end

            oldq_pkg::ST_SHIFT:
            begin
                // move the element just read one place toward the front
                wr_en          = 1'b1;
                wr_addr        = prev_slot_reg;
                wr_data        = rd_data;
                prev_slot_next = rd_addr_reg;
                if (idx_inc < count_reg)
                begin
                    rd_en    = 1'b1;
                    idx_next = idx_inc[AW-1:0];
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = oldq_pkg::ST_REPLY;
                end
            end

            oldq_pkg::ST_READOUT:
            begin
                push.item.status       = oldq_pkg::STATUS_OK;
                push.item.result_value = rd_data;
                push.item.last         = (idx_inc == count_reg);
                if (out_free)
                begin
                    push.valid = 1'b1;
                    if (idx_inc == count_reg)
                    begin
                        state_next = oldq_pkg::ST_IDLE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        idx_next = idx_inc[AW-1:0];
                    end
                end
            end

            oldq_pkg::ST_REPLY:
            begin
                if (out_free)
                begin
                    push.valid = 1'b1;
                    state_next = oldq_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = oldq_pkg::ST_IDLE;
            end
        endcase
    end

    `OLDQ_NEVER(a_count_range, clk, rst_n, count_reg > COUNT_MAX)
    `OLDQ_NEVER(a_head_range, clk, rst_n, head_reg > HEAD_MAX)
    `OLDQ_ASSERT(a_push_free, clk, rst_n, push.valid |-> out_free)
    `OLDQ_ASSERT(a_accept_decode, clk, rst_n, cmd_xfer |=> (state_reg == oldq_pkg::ST_DECODE))
    `OLDQ_ASSERT(a_shift_past_match, clk, rst_n, in_shift |-> (idx_reg != '0 && count_reg != '0))

endmodule
